@@ sv/local_lagrange_interpolator_defines.svh @@
// Assertion macros used by the interpolator evaluation engine.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef LOCAL_LAGRANGE_INTERPOLATOR_DEFINES_SVH
`define LOCAL_LAGRANGE_INTERPOLATOR_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define LLI_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// A condition that implies another in the same cycle.
`define LLI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/lli_pkg.sv @@
// Shared types and constants of the Lagrange interpolator.
// Depends on nothing.
package lli_pkg;

    localparam int MAX_KNOTS_DEF = 16;
    localparam int POS_WIDTH_DEF = 10;
    localparam int KNOT_POS_W    = 10;
    localparam int VAL_W         = 32;
    localparam int ORDER_W       = 4;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 3;

    localparam logic [CMD_W-1:0]   CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0]   CMD_APPEND  = 2'd1;
    localparam logic [CMD_W-1:0]   CMD_EVAL    = 2'd2;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd1;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] Q_ONE   = 32'sd65536;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_APPEND,
        K_EVAL,
        K_NOP
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_FULL  = 3'd2,
        ST_ORDER = 3'd3,
        ST_SAT   = 3'd4
    } t_status;

    typedef struct packed {
        logic signed [VAL_W-1:0] curve_val;
        t_status                 status;
        logic signed [VAL_W-1:0] min_seen;
        logic signed [VAL_W-1:0] max_seen;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ONE_RD,
        S_ONE,
        S_SCAN_RD,
        S_SCAN,
        S_BASE,
        S_XJ_RD,
        S_XJ,
        S_KSEL,
        S_XK_RD,
        S_MUL,
        S_DIVSET,
        S_DIV,
        S_CLAMP,
        S_TERM_RD
    } t_bstate;

    typedef enum logic [2:0] {
        A_IDLE,
        A_TERM,
        A_ACC,
        A_FINISH,
        A_OUT
    } t_astate;

endpackage

@@ sv/lli_front.sv @@
// Input stage: registers one word, decodes the command into an operation kind.
// Depends on lli_pkg.
module lli_front #(
    parameter int POS_WIDTH = lli_pkg::POS_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [lli_pkg::CMD_W-1:0]         i_cmd,
    input  logic [lli_pkg::KNOT_POS_W-1:0]    i_knot_pos,
    input  logic signed [lli_pkg::VAL_W-1:0]  i_knot_val,
    input  logic [lli_pkg::KNOT_POS_W-1:0]    i_query_pos,
    output logic                              o_push,
    input  logic                              i_full,
    output lli_pkg::t_kind                    o_kind,
    output logic [POS_WIDTH-1:0]              o_pos,
    output logic signed [lli_pkg::VAL_W-1:0]  o_val
);
    import lli_pkg::*;

    logic                    r_valid;
    t_kind                   r_kind;
    logic [POS_WIDTH-1:0]    r_pos;
    logic signed [VAL_W-1:0] r_val;
    t_kind                   n_kind;
    logic                    accept;

    always_comb begin
        unique case (i_cmd)
            CMD_CLEAR:  n_kind = K_CLEAR;
            CMD_APPEND: n_kind = K_APPEND;
            CMD_EVAL:   n_kind = K_EVAL;
            default:    n_kind = K_NOP;
        endcase
    end

    assign o_in_stall = r_valid & i_full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_push     = r_valid & ~i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // Only the position that the command uses travels on.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= n_kind;
            r_pos  <= (n_kind == K_EVAL) ? POS_WIDTH'(i_query_pos) : POS_WIDTH'(i_knot_pos);
            r_val  <= i_knot_val;
        end
    end

    assign o_kind = r_kind;
    assign o_pos  = r_pos;
    assign o_val  = r_val;

endmodule

@@ sv/lli_queue.sv @@
// Two-entry queue that decouples the decoder from the evaluation engine.
// Depends on lli_pkg for the kind type and value width.
module lli_queue #(
    parameter int POS_WIDTH = lli_pkg::POS_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  lli_pkg::t_kind                    i_kind,
    input  logic [POS_WIDTH-1:0]              i_pos,
    input  logic signed [lli_pkg::VAL_W-1:0]  i_val,
    output logic                              o_full,
    input  logic                              i_pop,
    output logic                              o_valid,
    output lli_pkg::t_kind                    o_kind,
    output logic [POS_WIDTH-1:0]              o_pos,
    output logic signed [lli_pkg::VAL_W-1:0]  o_val
);
    import lli_pkg::*;

    localparam int EW = 2 + POS_WIDTH + VAL_W;

    logic [EW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic [EW-1:0] rd_word;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= {i_kind, i_pos, i_val};
        end
    end

    assign rd_word = r_mem[r_rp];
    assign o_kind  = t_kind'(rd_word[EW-1 -: 2]);
    assign o_pos   = rd_word[VAL_W +: POS_WIDTH];
    assign o_val   = rd_word[VAL_W-1:0];

endmodule

@@ sv/lli_back.sv @@
// Evaluation engine: knot table, window search, multiply and serial divide,
// accumulation, running min/max and the output register. Depends on lli_pkg.
module lli_back #(
    parameter int MAX_KNOTS = lli_pkg::MAX_KNOTS_DEF,
    parameter int POS_WIDTH = lli_pkg::POS_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  lli_pkg::t_kind                    i_q_kind,
    input  logic [POS_WIDTH-1:0]              i_q_pos,
    input  logic signed [lli_pkg::VAL_W-1:0]  i_q_val,
    output logic                              o_q_pop,
    input  logic                              i_cfg_we,
    input  logic [lli_pkg::ORDER_W-1:0]       i_cfg_wdata,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output lli_pkg::t_result                  o_result
);
    import lli_pkg::*;
    `include "local_lagrange_interpolator_defines.svh"

    localparam int IW    = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int CW    = $clog2(MAX_KNOTS + 1);
    localparam int OW    = (CW > ORDER_W) ? CW : ORDER_W;
    localparam int PRODW = VAL_W + POS_WIDTH + 1;
    localparam int DCW   = $clog2(PRODW + 1);
    localparam int TERMW = 2 * VAL_W - 16;
    localparam int SUMW  = TERMW + CW + 1;

    // Knot table, one read port with registered data.
    logic [POS_WIDTH-1:0]    pos_mem [MAX_KNOTS];
    logic signed [VAL_W-1:0] val_mem [MAX_KNOTS];

    t_bstate                 r_state, n_state;
    t_kind                   r_kind;
    logic [POS_WIDTH-1:0]    r_pos;
    logic signed [VAL_W-1:0] r_kval;
    logic [ORDER_W-1:0]      r_order;
    logic [CW-1:0]           r_count;
    logic [POS_WIDTH-1:0]    r_last_pos;
    logic signed [VAL_W-1:0] r_min, r_max;
    logic [CW-1:0]           r_ord, r_le, r_i, r_j, r_k;
    logic [IW-1:0]           r_base, r_addr;
    logic [POS_WIDTH-1:0]    r_pos_rd, r_xj;
    logic signed [VAL_W-1:0] r_val_rd;
    logic signed [VAL_W-1:0] r_b;
    logic signed [PRODW-1:0] r_prod;
    logic signed [POS_WIDTH:0] r_dsig;
    logic [PRODW-1:0]        r_num;
    logic [POS_WIDTH:0]      r_rem;
    logic [POS_WIDTH-1:0]    r_den;
    logic                    r_qneg;
    logic [DCW-1:0]          r_dcnt;
    logic signed [2*VAL_W-1:0] r_yb;
    logic signed [SUMW-1:0]  r_sum;
    logic                    r_sat;
    logic signed [VAL_W-1:0] r_res_val;
    t_status                 r_res_status;
    logic                    r_out_valid;
    t_result                 r_out;

    logic                    out_free;
    logic                    in_term;
    logic [OW-1:0]           ord_w;
    logic [CW-1:0]           ord_c;
    logic [IW-1:0]           base_c;
    logic [POS_WIDTH:0]      div_shift;
    logic [POS_WIDTH+1:0]    div_trial;
    logic signed [VAL_W-1:0] b_clamp;
    logic                    b_sat;
    logic signed [2*VAL_W-1:0] yb_shift;
    logic signed [TERMW-1:0] term;
    logic signed [VAL_W-1:0] sum_clamp;
    logic                    sum_sat;
    logic                    eval_ok;
    logic signed [VAL_W-1:0] n_min, n_max;
    logic                    append_ok;

    // Accumulation steps run in a separate sub-phase register beside the main
    // state register; it tracks the term, accumulate, final clamp and output steps.
    t_astate                 r_astate, n_astate;

    assign out_free = ~r_out_valid | ~i_out_stall;
    assign in_term  = (r_astate != A_IDLE);

    // Order clamp to 1 .. count-1.
    always_comb begin
        ord_w = OW'(r_order);
        if (ord_w > OW'(r_count) - OW'(1)) begin
            ord_w = OW'(r_count) - OW'(1);
        end
        if (ord_w < OW'(1)) begin
            ord_w = OW'(1);
        end
        ord_c = CW'(ord_w);
    end

    // Window start from the number of knots at or left of the query.
    always_comb begin
        int seg;
        int bs;
        seg = int'(r_le) - 1;
        bs  = 0;
        if (r_le == '0) begin
            bs = 0;
        end else if (r_le == r_count) begin
            bs = int'(r_count) - 1 - int'(r_ord);
        end else begin
            bs = seg - int'(r_ord >> 1);
            if (bs < 0) begin
                bs = 0;
            end
            if (bs + int'(r_ord) > int'(r_count) - 1) begin
                bs = int'(r_count) - 1 - int'(r_ord);
            end
        end
        base_c = IW'(bs);
    end

    // One restoring division step.
    assign div_shift = {r_rem[POS_WIDTH-1:0], r_num[PRODW-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, r_den};

    // Saturate the quotient magnitude back into Q16.16.
    always_comb begin
        b_sat = 1'b0;
        if (r_qneg) begin
            if ((|r_num[PRODW-1:VAL_W]) || (r_num[VAL_W-1] && (|r_num[VAL_W-2:0]))) begin
                b_clamp = VAL_MIN;
                b_sat   = 1'b1;
            end else begin
                b_clamp = -$signed(r_num[VAL_W-1:0]);
            end
        end else begin
            if (|r_num[PRODW-1:VAL_W-1]) begin
                b_clamp = VAL_MAX;
                b_sat   = 1'b1;
            end else begin
                b_clamp = $signed(r_num[VAL_W-1:0]);
            end
        end
    end

    // y * basis / 65536, truncated toward zero.
    always_comb begin
        yb_shift = r_yb >>> 16;
        if (r_yb[2*VAL_W-1] && (|r_yb[15:0])) begin
            yb_shift = yb_shift + 64'sd1;
        end
        term = yb_shift[TERMW-1:0];
    end

    always_comb begin
        sum_sat   = 1'b0;
        sum_clamp = r_sum[VAL_W-1:0];
        if (r_sum > SUMW'(VAL_MAX)) begin
            sum_clamp = VAL_MAX;
            sum_sat   = 1'b1;
        end else if (r_sum < SUMW'(VAL_MIN)) begin
            sum_clamp = VAL_MIN;
            sum_sat   = 1'b1;
        end
    end

    assign append_ok = (r_kind == K_APPEND) && (r_res_status == ST_OK);
    assign eval_ok   = (r_kind == K_EVAL) && (r_res_status != ST_EMPTY);

    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if (r_kind == K_CLEAR) begin
            n_min = VAL_MAX;
            n_max = VAL_MIN;
        end else if (eval_ok) begin
            if (r_res_val < r_min) begin
                n_min = r_res_val;
            end
            if (r_res_val > r_max) begin
                n_max = r_res_val;
            end
        end
    end

    // Next state of the main sequencer.
    always_comb begin
        n_state = r_state;
        if (!in_term) begin
            unique case (r_state)
                S_IDLE:    if (i_q_valid) n_state = S_DECODE;
                S_DECODE: begin
                    if (r_kind != K_EVAL || r_count == '0) begin
                        n_state = S_IDLE;
                    end else if (r_count == CW'(1)) begin
                        n_state = S_ONE_RD;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
                S_ONE_RD:  n_state = S_ONE;
                S_ONE:     n_state = S_IDLE;
                S_SCAN_RD: n_state = S_SCAN;
                S_SCAN:    n_state = (r_i == r_count - CW'(1)) ? S_BASE : S_SCAN_RD;
                S_BASE:    n_state = S_XJ_RD;
                S_XJ_RD:   n_state = S_XJ;
                S_XJ:      n_state = S_KSEL;
                S_KSEL: begin
                    if (r_k > r_ord) begin
                        n_state = S_TERM_RD;
                    end else if (r_k != r_j) begin
                        n_state = S_XK_RD;
                    end
                end
                S_XK_RD:   n_state = S_MUL;
                S_MUL:     n_state = S_DIVSET;
                S_DIVSET:  n_state = S_DIV;
                S_DIV:     n_state = (r_dcnt == DCW'(1)) ? S_CLAMP : S_DIV;
                S_CLAMP:   n_state = S_KSEL;
                S_TERM_RD: n_state = S_IDLE;
                default:   n_state = S_IDLE;
            endcase
        end else if (r_astate == A_ACC && r_j != r_ord) begin
            n_state = S_XJ_RD;
        end
    end

    // Next sub-phase: term, accumulate, final clamp, output.
    always_comb begin
        n_astate = r_astate;
        unique case (r_astate)
            A_IDLE: begin
                if (r_state == S_TERM_RD) begin
                    n_astate = A_TERM;
                end else if ((r_state == S_DECODE &&
                              (r_kind != K_EVAL || r_count == '0)) ||
                             r_state == S_ONE) begin
                    n_astate = A_OUT;
                end
            end
            A_TERM:   n_astate = A_ACC;
            A_ACC:    n_astate = (r_j == r_ord) ? A_FINISH : A_IDLE;
            A_FINISH: n_astate = A_OUT;
            A_OUT:    n_astate = out_free ? A_IDLE : A_OUT;
            default:  n_astate = A_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_q_pop = (r_state == S_IDLE) && !in_term && i_q_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_astate <= A_IDLE;
        end else begin
            // Hold the main sequencer in idle until the result has left.
            r_state  <= (r_astate == A_OUT) ? S_IDLE : n_state;
            r_astate <= n_astate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
        end else if (i_cfg_we) begin
            r_order <= i_cfg_wdata;
        end
    end

    // Table commits and running statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min   <= VAL_MAX;
            r_max   <= VAL_MIN;
        end else if (r_astate == A_OUT && out_free) begin
            r_min <= n_min;
            r_max <= n_max;
            if (r_kind == K_CLEAR) begin
                r_count <= '0;
            end else if (append_ok) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_astate == A_OUT && out_free && append_ok) begin
            pos_mem[r_count[IW-1:0]] <= r_pos;
            val_mem[r_count[IW-1:0]] <= r_kval;
            r_last_pos               <= r_pos;
        end
        r_pos_rd <= pos_mem[r_addr];
        r_val_rd <= val_mem[r_addr];
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (!in_term) begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_kind <= i_q_kind;
                        r_pos  <= i_q_pos;
                        r_kval <= i_q_val;
                    end
                end
                S_DECODE: begin
                    r_res_val    <= '0;
                    r_res_status <= ST_OK;
                    r_sum        <= '0;
                    r_sat        <= 1'b0;
                    r_ord        <= ord_c;
                    r_le         <= '0;
                    r_i          <= '0;
                    r_addr       <= '0;
                    if (r_kind == K_APPEND) begin
                        if (r_count >= CW'(MAX_KNOTS)) begin
                            r_res_status <= ST_FULL;
                        end else if (r_count != '0 && r_pos <= r_last_pos) begin
                            r_res_status <= ST_ORDER;
                        end
                    end else if (r_kind == K_EVAL && r_count == '0) begin
                        r_res_status <= ST_EMPTY;
                    end
                end
                S_ONE: begin
                    r_res_val <= r_val_rd;
                end
                S_SCAN: begin
                    if (r_pos_rd <= r_pos) begin
                        r_le <= r_le + CW'(1);
                    end
                    r_i    <= r_i + CW'(1);
                    r_addr <= IW'(r_i + CW'(1));
                end
                S_BASE: begin
                    r_base <= base_c;
                    r_j    <= '0;
                    r_addr <= base_c;
                end
                S_XJ: begin
                    r_xj <= r_pos_rd;
                    r_b  <= Q_ONE;
                    r_k  <= '0;
                end
                S_KSEL: begin
                    if (r_k > r_ord) begin
                        r_addr <= IW'(r_base + IW'(r_j));
                    end else if (r_k == r_j) begin
                        r_k <= r_k + CW'(1);
                    end else begin
                        r_addr <= IW'(r_base + IW'(r_k));
                    end
                end
                S_MUL: begin
                    r_prod <= PRODW'(r_b) *
                              PRODW'($signed({1'b0, r_pos}) - $signed({1'b0, r_pos_rd}));
                    r_dsig <= $signed({1'b0, r_xj}) - $signed({1'b0, r_pos_rd});
                end
                S_DIVSET: begin
                    r_num  <= r_prod[PRODW-1] ? PRODW'(-r_prod) : PRODW'(r_prod);
                    r_den  <= r_dsig[POS_WIDTH] ? POS_WIDTH'(-r_dsig) : POS_WIDTH'(r_dsig);
                    r_qneg <= r_prod[PRODW-1] ^ r_dsig[POS_WIDTH];
                    r_rem  <= '0;
                    r_dcnt <= DCW'(PRODW);
                end
                S_DIV: begin
                    if (!div_trial[POS_WIDTH+1]) begin
                        r_rem <= div_trial[POS_WIDTH:0];
                        r_num <= {r_num[PRODW-2:0], 1'b1};
                    end else begin
                        r_rem <= div_shift;
                        r_num <= {r_num[PRODW-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - DCW'(1);
                end
                S_CLAMP: begin
                    r_b <= b_clamp;
                    if (b_sat) begin
                        r_sat <= 1'b1;
                    end
                    r_k <= r_k + CW'(1);
                end
                default: begin
                end
            endcase
        end else begin
            unique case (r_astate)
                A_TERM: begin
                    r_yb <= (2*VAL_W)'(r_val_rd) * (2*VAL_W)'(r_b);
                end
                A_ACC: begin
                    r_sum <= r_sum + SUMW'(term);
                    if (r_j != r_ord) begin
                        r_j    <= r_j + CW'(1);
                        r_addr <= IW'(r_base + IW'(r_j) + IW'(1));
                    end
                end
                A_FINISH: begin
                    r_res_val <= sum_clamp;
                    if (sum_sat || r_sat) begin
                        r_res_status <= ST_SAT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_astate == A_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_astate == A_OUT && out_free) begin
            r_out.curve_val <= r_res_val;
            r_out.status    <= r_res_status;
            r_out.min_seen  <= n_min;
            r_out.max_seen  <= n_max;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    `LLI_ASSERT_HOLDS(a_count_range, r_count <= CW'(MAX_KNOTS), "knot count beyond table size")
    `LLI_ASSERT_IMP(a_div_nonzero, r_state == S_DIV && !in_term, r_den != '0,
        "division by a zero knot distance")
    `LLI_ASSERT_IMP(a_window_inside, r_state == S_MUL && !in_term,
        ({1'b0, r_base} + (CW+1)'(r_ord)) < (CW+1)'(r_count),
        "interpolation window runs past the last knot")

endmodule

@@ sv/local_lagrange_interpolator.sv @@
// Piecewise Lagrange interpolator over a table of up to MAX_KNOTS knots.
// Input word: cmd, knot_pos, knot_val, query_pos; accepted when i_in_valid is
//   high and o_in_stall low. Commands: clear, append knot, evaluate, no-op.
// Output word: curve_val, status, min_seen, max_seen; one word per input word,
//   taken when o_out_valid is high and i_out_stall low.
// i_cfg_we writes the requested interpolation order from i_cfg_wdata.
// An evaluation forms each basis through a serial divider, one quotient bit per
//   cycle over the (POS_WIDTH+33)-bit product. Words are worked one at a time.
// A two-word queue sits behind the input register, so up to three words are
//   taken while an evaluation runs or the receiver stalls; o_in_stall rises when
//   it fills. A stalled output word holds its value.
// Reset empties the table, sets min to the most positive and max to the most
//   negative value and the order to linear. Table contents need no clearing.
// Depends on lli_pkg, lli_front, lli_queue and lli_back.
module local_lagrange_interpolator #(
    parameter int MAX_KNOTS = lli_pkg::MAX_KNOTS_DEF,
    parameter int POS_WIDTH = lli_pkg::POS_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [lli_pkg::CMD_W-1:0]           i_cmd,
    input  logic [lli_pkg::KNOT_POS_W-1:0]      i_knot_pos,
    input  logic signed [lli_pkg::VAL_W-1:0]    i_knot_val,
    input  logic [lli_pkg::KNOT_POS_W-1:0]      i_query_pos,
    input  logic                                i_cfg_we,
    input  logic [lli_pkg::ORDER_W-1:0]         i_cfg_wdata,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [lli_pkg::VAL_W-1:0]    o_curve_val,
    output logic [lli_pkg::STATUS_W-1:0]        o_status,
    output logic signed [lli_pkg::VAL_W-1:0]    o_min_seen,
    output logic signed [lli_pkg::VAL_W-1:0]    o_max_seen
);
    import lli_pkg::*;

    logic                    push, full, pop, q_valid;
    t_kind                   f_kind, q_kind;
    logic [POS_WIDTH-1:0]    f_pos, q_pos;
    logic signed [VAL_W-1:0] f_val, q_val;
    t_result                 result;

    lli_front #(.POS_WIDTH(POS_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_knot_pos  (i_knot_pos),
        .i_knot_val  (i_knot_val),
        .i_query_pos (i_query_pos),
        .o_push      (push),
        .i_full      (full),
        .o_kind      (f_kind),
        .o_pos       (f_pos),
        .o_val       (f_val)
    );

    lli_queue #(.POS_WIDTH(POS_WIDTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_kind  (f_kind),
        .i_pos   (f_pos),
        .i_val   (f_val),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_kind  (q_kind),
        .o_pos   (q_pos),
        .o_val   (q_val)
    );

    lli_back #(.MAX_KNOTS(MAX_KNOTS), .POS_WIDTH(POS_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_kind    (q_kind),
        .i_q_pos     (q_pos),
        .i_q_val     (q_val),
        .o_q_pop     (pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_curve_val = result.curve_val;
    assign o_status    = result.status;
    assign o_min_seen  = result.min_seen;
    assign o_max_seen  = result.max_seen;

endmodule

@@ dv/lli_checker.sv @@
// Checker for the Lagrange interpolator: watches the input, output and order
// register ports, predicts each output word and compares it field by field.
// Depends on lli_pkg.
module lli_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [lli_pkg::CMD_W-1:0]        i_cmd,
    input  logic [lli_pkg::KNOT_POS_W-1:0]   i_knot_pos,
    input  logic signed [lli_pkg::VAL_W-1:0] i_knot_val,
    input  logic [lli_pkg::KNOT_POS_W-1:0]   i_query_pos,
    input  logic                             i_cfg_we,
    input  logic [lli_pkg::ORDER_W-1:0]      i_cfg_wdata,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic signed [lli_pkg::VAL_W-1:0] i_curve_val,
    input  logic [lli_pkg::STATUS_W-1:0]     i_status,
    input  logic signed [lli_pkg::VAL_W-1:0] i_min_seen,
    input  logic signed [lli_pkg::VAL_W-1:0] i_max_seen,
    output int                               o_fail_count,
    output int                               o_pending
);
    import lli_pkg::*;

    localparam int NKNOTS = MAX_KNOTS_DEF;

    logic [KNOT_POS_W-1:0] tbl_pos [NKNOTS];
    logic signed [VAL_W-1:0] tbl_val [NKNOTS];
    int unsigned tbl_count;
    logic signed [VAL_W-1:0] seen_lo, seen_hi;
    logic [ORDER_W-1:0] req_order;
    t_result expected_words[$];
    int fails;
    int pend;

    assign o_fail_count = fails;
    assign o_pending    = pend;

    function automatic longint clamp_s32(input longint v, inout bit sat);
        if (v > longint'(VAL_MAX)) begin
            sat = 1'b1;
            return longint'(VAL_MAX);
        end
        if (v < longint'(VAL_MIN)) begin
            sat = 1'b1;
            return longint'(VAL_MIN);
        end
        return v;
    endfunction

    function automatic longint lagrange_at(input longint q, inout bit sat);
        int n, ord, base, seg;
        longint xj, xk, b, sum;
        n = tbl_count;
        ord = req_order;
        sum = 0;
        if (ord > n - 1) ord = n - 1;
        if (ord < 1) ord = 1;
        if (longint'(tbl_pos[0]) > q) begin
            base = 0;
        end else if (longint'(tbl_pos[n-1]) <= q) begin
            base = n - 1 - ord;
        end else begin
            seg = n - 1;
            for (int j = 0; j < n - 1; j++) begin
                if (longint'(tbl_pos[j]) <= q && longint'(tbl_pos[j+1]) > q) begin
                    seg = j;
                    break;
                end
            end
            base = seg - ord / 2;
            if (base < 0) base = 0;
            if (base + ord > n - 1) base = n - 1 - ord;
        end
        for (int j = 0; j <= ord; j++) begin
            xj = longint'(tbl_pos[base+j]);
            b = longint'(Q_ONE);
            for (int k = 0; k <= ord; k++) begin
                if (k != j) begin
                    xk = longint'(tbl_pos[base+k]);
                    b = b * (q - xk);
                    if (xj != xk) b = b / (xj - xk);
                    b = clamp_s32(b, sat);
                end
            end
            sum += (longint'(tbl_val[base+j]) * b) / longint'(Q_ONE);
        end
        return clamp_s32(sum, sat);
    endfunction

    function automatic t_result predict_word(input logic [CMD_W-1:0] cmd,
                                             input logic [KNOT_POS_W-1:0] kpos,
                                             input logic signed [VAL_W-1:0] kval,
                                             input logic [KNOT_POS_W-1:0] qpos);
        t_result r;
        longint v;
        bit sat;
        v = 0;
        sat = 1'b0;
        r.status = ST_OK;
        if (cmd == CMD_CLEAR) begin
            tbl_count = 0;
            seen_lo = VAL_MAX;
            seen_hi = VAL_MIN;
        end else if (cmd == CMD_APPEND) begin
            if (tbl_count >= NKNOTS) begin
                r.status = ST_FULL;
            end else if (tbl_count > 0 && kpos <= tbl_pos[tbl_count-1]) begin
                r.status = ST_ORDER;
            end else begin
                tbl_pos[tbl_count] = kpos;
                tbl_val[tbl_count] = kval;
                tbl_count++;
            end
        end else if (cmd == CMD_EVAL) begin
            if (tbl_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                if (tbl_count == 1) v = longint'(tbl_val[0]);
                else v = lagrange_at(longint'(qpos), sat);
                if (sat) r.status = ST_SAT;
                if (v < longint'(seen_lo)) seen_lo = VAL_W'(v);
                if (v > longint'(seen_hi)) seen_hi = VAL_W'(v);
            end
        end
        r.curve_val = VAL_W'(v);
        r.min_seen = seen_lo;
        r.max_seen = seen_hi;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_w;
        if (!i_rst_n) begin
            tbl_count = 0;
            seen_lo = VAL_MAX;
            seen_hi = VAL_MIN;
            req_order = ORDER_RESET;
            expected_words.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) req_order = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: output word with none expected: val %h status %0d",
                             $time, i_curve_val, i_status);
                    fails++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (i_curve_val !== exp_w.curve_val) begin
                        $display("%0t: curve_val expected %h actual %h",
                                 $time, exp_w.curve_val, i_curve_val);
                        fails++;
                    end
                    if (i_status !== exp_w.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_w.status, i_status);
                        fails++;
                    end
                    if (i_min_seen !== exp_w.min_seen) begin
                        $display("%0t: min_seen expected %h actual %h",
                                 $time, exp_w.min_seen, i_min_seen);
                        fails++;
                    end
                    if (i_max_seen !== exp_w.max_seen) begin
                        $display("%0t: max_seen expected %h actual %h",
                                 $time, exp_w.max_seen, i_max_seen);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                exp_w = predict_word(i_cmd, i_knot_pos, i_knot_val, i_query_pos);
                expected_words = {expected_words, exp_w};
            end
        end
        pend = expected_words.size();
    end
endmodule

@@ dv/local_lagrange_interpolator_tb.sv @@
// Top of the interpolator testbench: drives knot tables, evaluations and order
// settings with random gaps and stalls, and gives the verdict.
// Depends on lli_pkg, local_lagrange_interpolator and lli_checker.
module local_lagrange_interpolator_tb;
    import lli_pkg::*;

    localparam int ITEM_TARGET = 400;
    localparam int IDLE_LIMIT  = 60000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [CMD_W-1:0] i_cmd = CMD_CLEAR;
    logic [KNOT_POS_W-1:0] i_knot_pos = '0;
    logic signed [VAL_W-1:0] i_knot_val = '0;
    logic [KNOT_POS_W-1:0] i_query_pos = '0;
    logic i_cfg_we = 1'b0;
    logic [ORDER_W-1:0] i_cfg_wdata = ORDER_RESET;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [VAL_W-1:0] o_curve_val, o_min_seen, o_max_seen;
    logic [STATUS_W-1:0] o_status;

    int fail_count, pending;
    int words_sent = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    always #1 i_clk = ~i_clk;

    local_lagrange_interpolator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_cmd(i_cmd), .i_knot_pos(i_knot_pos), .i_knot_val(i_knot_val),
        .i_query_pos(i_query_pos),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_curve_val(o_curve_val), .o_status(o_status),
        .o_min_seen(o_min_seen), .o_max_seen(o_max_seen)
    );

    lli_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_cmd(i_cmd), .i_knot_pos(i_knot_pos), .i_knot_val(i_knot_val),
        .i_query_pos(i_query_pos),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_curve_val(o_curve_val), .i_status(o_status),
        .i_min_seen(o_min_seen), .i_max_seen(o_max_seen),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: random stalls, a calm stretch, and one long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall = 1'b1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 300;
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = calm ? 1'b0 : ($urandom_range(0, 99) < 29);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL local_lagrange_interpolator");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [KNOT_POS_W-1:0] kpos,
                             input logic signed [VAL_W-1:0] kval,
                             input logic [KNOT_POS_W-1:0] qpos);
        while (!calm && $urandom_range(0, 99) < 29) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_cmd = cmd;
        i_knot_pos = kpos;
        i_knot_val = kval;
        i_query_pos = qpos;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        words_sent++;
        if (words_sent == 120) hold_req = 1'b1;
        calm = (words_sent >= 220 && words_sent < 290);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_order(input logic [ORDER_W-1:0] ord);
        wait_idle();
        i_cfg_we = 1'b1;
        i_cfg_wdata = ord;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
        if (sel < 70) return $urandom;
        if (sel < 85) begin
            case ($urandom_range(0, 3))
                0: return VAL_MAX;
                1: return VAL_MIN;
                2: return '0;
                default: return '1;
            endcase
        end
        return $signed($urandom_range(0, 2000 * 65536)) - 1000 * 65536;
    endfunction

    // Usually a clear, then an ascending knot table with some rejected knots, then evaluations.
    task automatic knot_sequence();
        int n, gap;
        int x, first_x, last_x;
        int q;
        n = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 6);
        if ($urandom_range(0, 4) != 0)
            send_word(CMD_CLEAR, KNOT_POS_W'($urandom), $urandom, KNOT_POS_W'($urandom));
        if ($urandom_range(0, 9) == 0)
            send_word(CMD_EVAL, KNOT_POS_W'($urandom), $urandom, KNOT_POS_W'($urandom));
        first_x = $urandom_range(0, 200);
        gap = (1023 - first_x) / n;
        x = first_x;
        last_x = first_x;
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 9) == 0)
                send_word(CMD_APPEND, KNOT_POS_W'($urandom_range(0, last_x)), pick_value(),
                          KNOT_POS_W'($urandom));
            send_word(CMD_APPEND, KNOT_POS_W'(x), pick_value(), KNOT_POS_W'($urandom));
            last_x = x;
            x = x + $urandom_range(1, gap);
        end
        if (n == 16)
            send_word(CMD_APPEND, KNOT_POS_W'($urandom), pick_value(), KNOT_POS_W'($urandom));
        for (int e = 0; e < ((n >= 12) ? 2 : $urandom_range(2, 6)); e++) begin
            case ($urandom_range(0, 4))
                0: q = $urandom_range(0, first_x);
                1: q = $urandom_range(last_x, 1023);
                2: q = $urandom_range(0, 1023);
                default: q = $urandom_range(first_x, last_x);
            endcase
            send_word(CMD_EVAL, KNOT_POS_W'($urandom), $urandom, KNOT_POS_W'(q));
        end
        if ($urandom_range(0, 9) == 0)
            send_word(~CMD_CLEAR, KNOT_POS_W'($urandom), $urandom, KNOT_POS_W'($urandom));
    endtask

    initial begin
        logic [ORDER_W-1:0] phase_orders [5];
        phase_orders = '{4'd15, 4'd2, 4'd3, ORDER_RESET, 4'd7};
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty table, single knot, rejected knots, extrapolation, fill-up.
        send_word(CMD_EVAL, '0, '0, 10'd512);
        send_word(CMD_APPEND, 10'd5, VAL_MAX, '0);
        send_word(CMD_EVAL, '0, '0, '0);
        send_word(CMD_APPEND, 10'd5, VAL_MIN, '0);
        send_word(CMD_APPEND, 10'd1023, VAL_MIN, '0);
        send_word(CMD_EVAL, '0, '0, '0);
        send_word(CMD_EVAL, '0, '0, 10'd1023);
        send_word(CMD_EVAL, '0, '0, 10'd600);
        send_word(~CMD_CLEAR, '1, '1, '1);
        send_word(CMD_CLEAR, '0, '0, '0);
        for (int i = 0; i < 16; i++)
            send_word(CMD_APPEND, 10'(i * 60), (i % 2) ? VAL_MAX : VAL_MIN, '0);
        send_word(CMD_APPEND, 10'd1000, '0, '0);
        send_word(CMD_EVAL, '0, '0, 10'd1023);

        for (int p = 0; p < 5; p++) begin
            write_order((p == 4) ? ORDER_W'($urandom_range(1, 15)) : phase_orders[p]);
            while (words_sent < 30 + (p + 1) * (ITEM_TARGET / 5)) knot_sequence();
        end

        i_in_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS local_lagrange_interpolator");
        end else begin
            $display("FAIL local_lagrange_interpolator");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+sv
sv/lli_pkg.sv
sv/lli_front.sv
sv/lli_queue.sv
sv/lli_back.sv
sv/local_lagrange_interpolator.sv
dv/lli_checker.sv
dv/local_lagrange_interpolator_tb.sv
